/* src/bsf_pkg.sv */
// ----------------------------------------------------------------------------
// bsf_pkg
// shared types and constants for the bounded substring finder
// ----------------------------------------------------------------------------
`default_nettype none

package bsf_pkg;

  localparam int PATTERN_MAX_DEF = 16;
  localparam int TEXT_MAX_DEF    = 4096;

  localparam int CHAR_W     = 8;
  localparam int PAT_SLOTS  = 16;
  localparam int PAT_LEN_W  = 5;
  localparam int MAX_LEN_W  = 13;
  localparam int POS_W      = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;
  localparam int SEL_W      = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_LOW    = 2'd0,
    CFG_PATTERN_HIGH   = 2'd1,
    CFG_PATTERN_LENGTH = 2'd2,
    CFG_MAX_LENGTH     = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    STATUS_FOUND     = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_LEN_ERROR = 2'd2
  } status_e;

  typedef logic [PAT_SLOTS-1:0][CHAR_W-1:0] pattern_t;

  typedef struct packed {
    logic [CHAR_W-1:0] text_char;
    logic              terminator;
  } in_item_t;

  typedef struct packed {
    status_e          status;
    logic [POS_W-1:0] match_position;
  } out_item_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } win_ctrl_t;

endpackage

`default_nettype wire

/* src/bsf_stream_if.sv */
// ----------------------------------------------------------------------------
// bsf_stream_if
// valid/ready channel carrying one payload per transaction
// ----------------------------------------------------------------------------
`default_nettype none

interface bsf_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* src/bsf_cell.sv */
// ----------------------------------------------------------------------------
// bsf_cell
// one window cell: holds a text character, passes it on and compares the
// incoming character against its pattern character
// ----------------------------------------------------------------------------
`default_nettype none

module bsf_cell #(
  parameter int IDX = 0
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire bsf_pkg::win_ctrl_t                  ctrl_i,
  input  wire logic [bsf_pkg::CHAR_W-1:0]          char_i,
  input  wire bsf_pkg::pattern_t                   pattern_i,
  input  wire logic [bsf_pkg::PAT_LEN_W-1:0]       pat_len_i,
  output logic      [bsf_pkg::CHAR_W-1:0]          char_o,
  output logic                                     hit_o
);

  logic [bsf_pkg::CHAR_W-1:0]    char_q, char_d;
  logic [bsf_pkg::SEL_W-1:0]     sel;
  logic                          active;

  assign active = pat_len_i > bsf_pkg::PAT_LEN_W'(IDX);
  assign sel    = bsf_pkg::SEL_W'(pat_len_i - bsf_pkg::PAT_LEN_W'(IDX) - 5'd1);
  // cell holds window entry IDX after the shift, so compare the incoming char
  assign hit_o  = !active || (char_i == pattern_i[sel]);

  always_comb begin
    char_d = char_q;
    if (ctrl_i.clear) begin
      char_d = '0;
    end else if (ctrl_i.shift) begin
      char_d = char_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_q <= '0;
    end else begin
      char_q <= char_d;
    end
  end

  assign char_o = char_q;

endmodule

`default_nettype wire

/* src/bsf_ctrl.sv */
// ----------------------------------------------------------------------------
// bsf_ctrl
// handshake, length count, first match record and result register
// ----------------------------------------------------------------------------
`default_nettype none

module bsf_ctrl #(
  parameter int PATTERN_MAX = bsf_pkg::PATTERN_MAX_DEF,
  parameter int TEXT_MAX    = bsf_pkg::TEXT_MAX_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  bsf_stream_if.sink                              text_in,
  bsf_stream_if.source                            result_out,
  input  wire logic [bsf_pkg::PAT_LEN_W-1:0]      pat_len_i,
  input  wire logic [bsf_pkg::MAX_LEN_W-1:0]      max_len_i,
  input  wire logic                               win_match_i,
  output bsf_pkg::win_ctrl_t                      win_ctrl_o
);

  localparam int CNT_W = $clog2(TEXT_MAX + 2);

  localparam logic [CNT_W-1:0]              CntMax  = CNT_W'(TEXT_MAX);
  localparam logic [bsf_pkg::MAX_LEN_W-1:0] LimMax  = bsf_pkg::MAX_LEN_W'(TEXT_MAX);
  localparam logic [bsf_pkg::PAT_LEN_W-1:0] PatMax  = bsf_pkg::PAT_LEN_W'(PATTERN_MAX);

  logic [CNT_W-1:0]          count_q, count_d, count_nxt;
  logic                      seen_q, seen_d;
  logic [bsf_pkg::POS_W-1:0] start_q, start_d;
  logic                      out_valid_q, out_valid_d;
  bsf_pkg::out_item_t        out_item_q, out_item_d;

  logic                              accept;
  logic                              is_term;
  logic                              hit;
  logic [bsf_pkg::MAX_LEN_W-1:0]     limit;
  logic                              len_err;
  logic [CNT_W-1:0]                  diff;

  assign text_in.ready = !out_valid_q || result_out.ready;
  assign accept        = text_in.valid && text_in.ready;
  assign is_term       = text_in.payload.terminator;

  assign win_ctrl_o.shift = accept && !is_term;
  assign win_ctrl_o.clear = accept && is_term;

  assign count_nxt = (count_q <= CntMax) ? count_q + 1'b1 : count_q;
  assign diff      = count_nxt - CNT_W'(pat_len_i);
  assign hit       = !seen_q && (pat_len_i != '0) && (pat_len_i <= PatMax) &&
                     (count_nxt <= CntMax) && (count_nxt >= CNT_W'(pat_len_i)) &&
                     win_match_i;

  assign limit   = (max_len_i < LimMax) ? max_len_i : LimMax;
  assign len_err = (bsf_pkg::MAX_LEN_W'(count_q) > limit) ||
                   (bsf_pkg::MAX_LEN_W'(pat_len_i) > limit) ||
                   (pat_len_i > PatMax);

  always_comb begin
    count_d     = count_q;
    seen_d      = seen_q;
    start_d     = start_q;
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    if (result_out.ready) begin
      out_valid_d = 1'b0;
    end
    if (accept) begin
      if (is_term) begin
        out_valid_d               = 1'b1;
        out_item_d.match_position = '0;
        if (len_err) begin
          out_item_d.status = bsf_pkg::STATUS_LEN_ERROR;
        end else if (seen_q) begin
          out_item_d.status         = bsf_pkg::STATUS_FOUND;
          out_item_d.match_position = start_q;
        end else begin
          out_item_d.status = bsf_pkg::STATUS_NOT_FOUND;
        end
        count_d = '0;
        seen_d  = 1'b0;
        start_d = '0;
      end else begin
        count_d = count_nxt;
        if (hit) begin
          seen_d  = 1'b1;
          start_d = bsf_pkg::POS_W'(diff);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      seen_q      <= 1'b0;
      start_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      seen_q      <= seen_d;
      start_q     <= start_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
  end

  assign result_out.valid   = out_valid_q;
  assign result_out.payload = out_item_q;

endmodule

`default_nettype wire

/* src/bounded_substring_finder_top.sv */
// ----------------------------------------------------------------------------
// bounded_substring_finder_top
// streams text characters through a row of compare cells and reports the
// first match of the configured pattern, not-found or a length error at each terminator transaction
// ----------------------------------------------------------------------------
// result: valid in the cycle after the terminator transaction
// throughput: one transaction per cycle unless a held result waits on result_out.ready;
//   the window compare across the cell row is combinational
// reset: pattern registers clear, max_length returns to 4096, window,
//   count and match record clear, no result pending
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_substring_finder_top #(
  parameter int PATTERN_MAX = bsf_pkg::PATTERN_MAX_DEF,
  parameter int TEXT_MAX    = bsf_pkg::TEXT_MAX_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [bsf_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [bsf_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  bsf_stream_if.sink                              text_in,
  bsf_stream_if.source                            result_out
);

  logic [bsf_pkg::CFG_DATA_W-1:0] pat_low_q, pat_high_q;
  logic [bsf_pkg::PAT_LEN_W-1:0]  pat_len_q;
  logic [bsf_pkg::MAX_LEN_W-1:0]  max_len_q;

  bsf_pkg::pattern_t              pattern;
  bsf_pkg::win_ctrl_t             win_ctrl;
  logic [PATTERN_MAX-1:0][bsf_pkg::CHAR_W-1:0] win_char;
  logic [PATTERN_MAX-1:0]         hit;
  logic                           win_match;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= '0;
      pat_high_q <= '0;
      pat_len_q  <= '0;
      max_len_q  <= bsf_pkg::MAX_LEN_W'(4096);
    end else if (cfg_we_i) begin
      case (bsf_pkg::cfg_idx_e'(cfg_index_i))
        bsf_pkg::CFG_PATTERN_LOW:    pat_low_q  <= cfg_data_i;
        bsf_pkg::CFG_PATTERN_HIGH:   pat_high_q <= cfg_data_i;
        bsf_pkg::CFG_PATTERN_LENGTH: pat_len_q  <= cfg_data_i[bsf_pkg::PAT_LEN_W-1:0];
        bsf_pkg::CFG_MAX_LENGTH:     max_len_q  <= cfg_data_i[bsf_pkg::MAX_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign pattern = {pat_high_q, pat_low_q};

  for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
    logic [bsf_pkg::CHAR_W-1:0] cell_in;
    if (j == 0) begin : g_head
      assign cell_in = text_in.payload.text_char;
    end else begin : g_link
      assign cell_in = win_char[j-1];
    end
    bsf_cell #(
      .IDX (j)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (win_ctrl),
      .char_i    (cell_in),
      .pattern_i (pattern),
      .pat_len_i (pat_len_q),
      .char_o    (win_char[j]),
      .hit_o     (hit[j])
    );
  end

  assign win_match = &hit;

  bsf_ctrl #(
    .PATTERN_MAX (PATTERN_MAX),
    .TEXT_MAX    (TEXT_MAX)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .text_in     (text_in),
    .result_out  (result_out),
    .pat_len_i   (pat_len_q),
    .max_len_i   (max_len_q),
    .win_match_i (win_match),
    .win_ctrl_o  (win_ctrl)
  );

endmodule

`default_nettype wire

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// streams directed and random texts through the bounded substring finder,
// rewrites the pattern settings between texts and checks each result
// transaction against an in-bench search model
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

  localparam int PAT_MAX      = bsf_pkg::PATTERN_MAX_DEF;
  localparam int TXT_MAX      = bsf_pkg::TEXT_MAX_DEF;
  localparam int GAP_MAX      = 12;
  localparam int HOLD_LEN     = 400;
  localparam int SETTLE       = 8;
  localparam int STALL_LIMIT  = 4000;
  localparam int RANDOM_ITEMS = 800;

  logic                           clk_i       = 1'b0;
  logic                           rst_ni      = 1'b0;
  logic                           cfg_we_i    = 1'b0;
  logic [bsf_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [bsf_pkg::CFG_DATA_W-1:0] cfg_data_i  = '0;

  bsf_stream_if #(.payload_t(bsf_pkg::in_item_t))  text_if ();
  bsf_stream_if #(.payload_t(bsf_pkg::out_item_t)) result_if ();

  bounded_substring_finder_top DUT (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_data_i,
    .text_in    (text_if),
    .result_out (result_if)
  );

  always #2 clk_i = ~clk_i;

  // search model state
  logic [63:0]               pat_lo_m  = '0;
  logic [63:0]               pat_hi_m  = '0;
  logic [4:0]                pat_len_m = '0;
  logic [12:0]               max_len_m = 13'(TXT_MAX);
  logic [7:0]                window_m [PAT_MAX];
  int                        count_m   = 0;
  bit                        seen_m    = 1'b0;
  logic [bsf_pkg::POS_W-1:0] start_m   = '0;

  bsf_pkg::out_item_t expected_reports [$];
  bsf_pkg::in_item_t  pending_items [$];
  logic [7:0] alphabet [4];

  int errors        = 0;
  int queued_total  = 0;
  int taken_total   = 0;
  int stall_cycles  = 0;
  int src_gap       = 0;
  int sink_gap      = 0;
  int hold_left     = 0;
  int hold_requests = 0;
  int holds_started = 0;
  bit quiet         = 1'b0;
  bit text_taken    = 1'b0;
  bit res_taken     = 1'b0;

  initial foreach (window_m[k]) window_m[k] = '0;

  function automatic void search_step(bsf_pkg::in_item_t item);
    int                 len;
    int                 limit;
    bit                 hit;
    logic [127:0]       pat;
    bsf_pkg::out_item_t rep;
    len = pat_len_m;
    pat = {pat_hi_m, pat_lo_m};
    if (!item.terminator) begin
      for (int i = PAT_MAX - 1; i > 0; i--) window_m[i] = window_m[i-1];
      window_m[0] = item.text_char;
      if (count_m <= TXT_MAX) count_m++;
      if (!seen_m && len >= 1 && len <= PAT_MAX && count_m <= TXT_MAX && count_m >= len) begin
        hit = 1'b1;
        for (int i = 0; i < len; i++) begin
          if (window_m[len-1-i] != pat[8*i +: 8]) hit = 1'b0;
        end
        if (hit) begin
          seen_m  = 1'b1;
          start_m = bsf_pkg::POS_W'(count_m - len);
        end
      end
    end else begin
      limit = (max_len_m < TXT_MAX) ? int'(max_len_m) : TXT_MAX;
      rep.match_position = '0;
      if (count_m > limit || len > limit || len > PAT_MAX) begin
        rep.status = bsf_pkg::STATUS_LEN_ERROR;
      end else if (seen_m) begin
        rep.status         = bsf_pkg::STATUS_FOUND;
        rep.match_position = start_m;
      end else begin
        rep.status = bsf_pkg::STATUS_NOT_FOUND;
      end
      expected_reports.push_back(rep);
      foreach (window_m[k]) window_m[k] = '0;
      count_m = 0;
      seen_m  = 1'b0;
      start_m = '0;
    end
  endfunction

  task automatic report_mismatch(string what);
    $display("ERROR at %0t: %s", $time, what);
    errors++;
  endtask

  task automatic check_report(bsf_pkg::out_item_t got);
    bsf_pkg::out_item_t want;
    if (expected_reports.size() == 0) begin
      report_mismatch($sformatf("result with none pending: status %0d position %0d",
                                got.status, got.match_position));
    end else begin
      want = expected_reports.pop_front();
      if (got.status !== want.status)
        report_mismatch($sformatf("status %0d, predicted %0d", got.status, want.status));
      if (got.match_position !== want.match_position)
        report_mismatch($sformatf("match_position %0d, predicted %0d",
                                  got.match_position, want.match_position));
    end
  endtask

  function automatic int draw_gap();
    return quiet ? 0 : $urandom_range(0, GAP_MAX);
  endfunction

  function automatic logic [7:0] pick_char();
    return ($urandom_range(0, 15) == 0) ? 8'($urandom) : alphabet[$urandom_range(0, 3)];
  endfunction

  // monitor and watchdog
  always @(posedge clk_i) begin
    text_taken <= rst_ni && text_if.valid && text_if.ready;
    res_taken  <= rst_ni && result_if.valid && result_if.ready;
    if (rst_ni) begin
      if (text_if.valid && text_if.ready) begin
        search_step(text_if.payload);
        taken_total++;
      end
      if (result_if.valid && result_if.ready) check_report(result_if.payload);
      if ((text_if.valid && text_if.ready) || (result_if.valid && result_if.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("bounded_substring_finder_top: mismatch");
          $finish;
        end
      end
    end
  end

  // text driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      text_if.valid <= 1'b0;
    end else if (!(text_if.valid && !text_taken)) begin
      if (src_gap > 0) begin
        src_gap--;
        text_if.valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        text_if.payload <= pending_items.pop_front();
        text_if.valid   <= 1'b1;
        if ($urandom_range(0, 63) == 0) quiet = !quiet;
        src_gap = draw_gap();
      end else begin
        text_if.valid <= 1'b0;
      end
    end
  end

  // result sink with occasional long hold-off
  always @(negedge clk_i) begin
    if (res_taken || (sink_gap == 0 && $urandom_range(0, 7) == 0)) sink_gap = draw_gap();
    else if (sink_gap > 0) sink_gap--;
    if (holds_started != hold_requests) begin
      holds_started = hold_requests;
      hold_left     = HOLD_LEN;
    end else if (hold_left > 0) begin
      hold_left--;
    end
    result_if.ready <= rst_ni && sink_gap == 0 && hold_left == 0;
  end

  task automatic push_char(logic [7:0] ch);
    pending_items.push_back({ch, 1'b0});
    queued_total++;
  endtask

  task automatic push_end();
    pending_items.push_back({8'($urandom), 1'b1});
    queued_total++;
  endtask

  task automatic write_reg(bsf_pkg::cfg_idx_e idx, logic [bsf_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    case (idx)
      bsf_pkg::CFG_PATTERN_LOW:    pat_lo_m  = data;
      bsf_pkg::CFG_PATTERN_HIGH:   pat_hi_m  = data;
      bsf_pkg::CFG_PATTERN_LENGTH: pat_len_m = data[bsf_pkg::PAT_LEN_W-1:0];
      bsf_pkg::CFG_MAX_LENGTH:     max_len_m = data[bsf_pkg::MAX_LEN_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic configure(logic [127:0] pat, int plen, int maxl);
    write_reg(bsf_pkg::CFG_PATTERN_LOW, pat[63:0]);
    write_reg(bsf_pkg::CFG_PATTERN_HIGH, pat[127:64]);
    write_reg(bsf_pkg::CFG_PATTERN_LENGTH, bsf_pkg::CFG_DATA_W'(plen));
    write_reg(bsf_pkg::CFG_MAX_LENGTH, bsf_pkg::CFG_DATA_W'(maxl));
  endtask

  // wait until every queued transaction is taken and every result is back
  task automatic settle();
    do @(negedge clk_i);
    while (taken_total != queued_total || expected_reports.size() != 0);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  initial begin : stimulus
    logic [127:0] pat;
    logic [7:0]   ch;
    int           phase;
    int           ntexts;
    int           tlen;
    int           plen;
    int           maxl;
    int           ins_len;
    int           where;
    int           flip;
    int           random_items;

    text_if.valid   = 1'b0;
    text_if.payload = '0;
    result_if.ready = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings, empty text
    push_end();
    settle();

    // pattern FF 00 41
    configure(128'h4100FF, 3, TXT_MAX);
    push_char(8'h41); push_char(8'hFF); push_char(8'h00); push_char(8'h41); push_end();
    push_char(8'hFF); push_char(8'h00); push_end();
    push_end();
    settle();
    configure(128'h4100FF, 0, TXT_MAX);
    push_char(8'hFF); push_end();
    settle();
    configure(128'h4100FF, PAT_MAX + 1, TXT_MAX);
    push_char(8'h41); push_end();
    settle();
    configure(128'h4100FF, 31, TXT_MAX);
    push_end();
    settle();
    // length error wins over a match
    configure(128'h4100FF, 3, 2);
    push_char(8'hFF); push_char(8'h00); push_char(8'h41); push_end();
    settle();
    configure(128'h4100FF, 2, 3);
    push_char(8'hFF); push_char(8'h00); push_char(8'h41); push_char(8'h41); push_end();
    settle();
    configure(128'h4100FF, 0, 0);
    push_end();
    settle();

    random_items = 0;
    phase        = 0;
    while (random_items < RANDOM_ITEMS) begin
      foreach (alphabet[k]) alphabet[k] = 8'($urandom);
      for (int k = 0; k < PAT_MAX; k++) pat[8*k +: 8] = pick_char();
      case ($urandom_range(0, 15))
        0:       plen = 0;
        1:       plen = $urandom_range(PAT_MAX + 1, 31);
        2, 3:    plen = PAT_MAX;
        default: plen = $urandom_range(1, 6);
      endcase
      case ($urandom_range(0, 7))
        0:       maxl = 8191;
        1:       maxl = $urandom_range(0, 24);
        2:       maxl = $urandom_range(0, 8191);
        default: maxl = TXT_MAX;
      endcase
      configure(pat, plen, maxl);
      ntexts = $urandom_range(2, 8);
      if (phase % 8 == 3) begin
        hold_requests++;
        ntexts = 30;
      end
      repeat (ntexts) begin
        tlen    = $urandom_range(0, 24);
        ins_len = ($urandom_range(0, 3) == 0) ? 0 : ((plen > PAT_MAX) ? PAT_MAX : plen);
        where   = $urandom_range(0, tlen);
        flip    = (ins_len > 0 && $urandom_range(0, 7) == 0) ? $urandom_range(0, ins_len - 1) : -1;
        for (int j = 0; j < tlen + ins_len; j++) begin
          if (j >= where && j < where + ins_len) begin
            ch = pat[8*(j-where) +: 8];
            if (j - where == flip) ch = ~ch;
          end else begin
            ch = pick_char();
          end
          push_char(ch);
        end
        push_end();
        random_items += tlen + ins_len + 1;
      end
      settle();
      phase++;
    end

    if (errors == 0) begin
      $display("bounded_substring_finder_top: match");
    end else begin
      $display("bounded_substring_finder_top: mismatch");
    end
    $finish;
  end

endmodule

/* sim.f */
src/bsf_pkg.sv
src/bsf_stream_if.sv
src/bsf_cell.sv
src/bsf_ctrl.sv
src/bounded_substring_finder_top.sv
verif/testbench.sv
